// ----- sv/ipc_pkg.sv -----
// Package for the interrupt priority controller.
// Holds the event codes, item and result types and the vector lookup; no dependencies.
package ipc_pkg;

    // Event codes carried on the input channel
    typedef enum logic [2:0] {
        ACT_WRITE   = 3'd0,
        ACT_READ    = 3'd1,
        ACT_REQUEST = 3'd2,
        ACT_SERVICE = 3'd3,
        ACT_TICK    = 3'd4,
        ACT_ENABLE  = 3'd5,
        ACT_DISABLE = 3'd6,
        ACT_HALT    = 3'd7
    } action_t;

    // Register select codes for bus reads and writes
    localparam logic REG_PENDING = 1'b0;  // pending flags, bus address 0xFF0F
    localparam logic REG_ENABLE  = 1'b1;  // enable mask, bus address 0xFFFF

    localparam int unsigned SRC_COUNT = 5;
    localparam int unsigned SRC_W     = 3;
    localparam logic [7:0]  VEC_BASE  = 8'h40;

    typedef struct packed {
        action_t                action;
        logic                   reg_select;
        logic [7:0]             write_data;
        logic [SRC_COUNT-1:0]   request_mask;
    } item_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic       vector_valid;
        logic [7:0] vector_address;
        logic       halted;
        logic       master_enabled;
    } result_t;

    // Jump target of a source: 0x40 plus eight per source number
    function automatic logic [7:0] vector_of(input logic [SRC_W-1:0] src);
        return VEC_BASE + {2'b00, src, 3'b000};
    endfunction

endpackage

// ----- sv/ipc_in_reg.sv -----
// Input register of the interrupt priority controller.
// Captures one item from the input channel; depends on ipc_pkg.
module ipc_in_reg
    import ipc_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  item_t                s_item,
    input  logic                 advance,
    output logic                 item_valid,
    output item_t                item
);

    logic  valid_reg;
    item_t item_reg;

    // Take a new item when empty or when the held one moves on this cycle
    assign s_ready = !valid_reg || advance;

    // Hold valid flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= s_valid;
        end
    end

    // Hold payload
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

// ----- sv/ipc_state.sv -----
// Controller state and per-item update logic.
// Holds IF/IE, master enable, countdowns and halt flag; depends on ipc_pkg.
module ipc_state
    import ipc_pkg::*;
#(
    parameter int unsigned SWITCH_DELAY = 2,
    parameter int unsigned CNT_W        = 2
) (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    advance,
    input  item_t   item,
    output result_t result
);

    localparam logic [CNT_W-1:0] DELAY_INIT = CNT_W'(SWITCH_DELAY);
    localparam logic [CNT_W-1:0] CNT_ONE    = CNT_W'(1);

    logic [7:0]       pend_reg, pend_next;
    logic [7:0]       ien_reg, ien_next;
    logic             me_reg, me_next;
    logic [CNT_W-1:0] dis_cnt_reg, dis_cnt_next;
    logic [CNT_W-1:0] en_cnt_reg, en_cnt_next;
    logic             halt_reg, halt_next;

    logic [SRC_COUNT-1:0] ready_src;
    logic [SRC_W-1:0]     src_sel;
    logic                 src_any;

    // Pick the lowest pending and enabled source
    always_comb begin
        ready_src = pend_reg[SRC_COUNT-1:0] & ien_reg[SRC_COUNT-1:0];
        src_sel   = '0;
        src_any   = |ready_src;
        for (int i = SRC_COUNT - 1; i >= 0; i--) begin
            if (ready_src[i]) begin
                src_sel = SRC_W'(i);
            end
        end
    end

    // Compute next state and result for the held item
    always_comb begin
        pend_next    = pend_reg;
        ien_next     = ien_reg;
        me_next      = me_reg;
        dis_cnt_next = dis_cnt_reg;
        en_cnt_next  = en_cnt_reg;
        halt_next    = halt_reg;
        result       = '0;

        unique case (item.action)
            ACT_WRITE: begin
                if (item.reg_select == REG_PENDING) begin
                    pend_next = item.write_data;
                end else begin
                    ien_next = item.write_data;
                end
            end
            ACT_READ: begin
                result.read_data = (item.reg_select == REG_PENDING) ? pend_reg : ien_reg;
            end
            ACT_REQUEST: begin
                if ((item.request_mask & ien_reg[SRC_COUNT-1:0]) != '0) begin
                    halt_next = 1'b0;
                end
                pend_next = pend_reg | {3'b000, item.request_mask};
            end
            ACT_SERVICE: begin
                if (me_reg && src_any) begin
                    pend_next[src_sel]    = 1'b0;
                    me_next               = 1'b0;
                    result.vector_valid   = 1'b1;
                    result.vector_address = vector_of(src_sel);
                end
            end
            ACT_TICK: begin
                // Disable countdown first, so enable wins when both expire
                if (dis_cnt_reg != '0) begin
                    if (dis_cnt_reg == CNT_ONE) begin
                        me_next = 1'b0;
                    end
                    dis_cnt_next = dis_cnt_reg - CNT_ONE;
                end
                if (en_cnt_reg != '0) begin
                    if (en_cnt_reg == CNT_ONE) begin
                        me_next = 1'b1;
                    end
                    en_cnt_next = en_cnt_reg - CNT_ONE;
                end
            end
            ACT_ENABLE: begin
                en_cnt_next  = DELAY_INIT;
                dis_cnt_next = '0;
            end
            ACT_DISABLE: begin
                dis_cnt_next = DELAY_INIT;
                en_cnt_next  = '0;
            end
            ACT_HALT: begin
                halt_next = 1'b1;
            end
            default: begin
                halt_next = halt_reg;
            end
        endcase

        result.halted         = halt_next;
        result.master_enabled = me_next;
    end

    // Commit state when the item moves to the result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg    <= '0;
            ien_reg     <= '0;
            me_reg      <= 1'b0;
            dis_cnt_reg <= '0;
            en_cnt_reg  <= '0;
            halt_reg    <= 1'b0;
        end else if (advance) begin
            pend_reg    <= pend_next;
            ien_reg     <= ien_next;
            me_reg      <= me_next;
            dis_cnt_reg <= dis_cnt_next;
            en_cnt_reg  <= en_cnt_next;
            halt_reg    <= halt_next;
        end
    end

endmodule

// ----- sv/interrupt_priority_controller_core.sv -----
// Top level of the interrupt priority controller: input register, state update, result register.
// Depends on ipc_pkg, ipc_in_reg and ipc_state.
//
//   Channel  Direction  Handshake          Payload
//   s_       in         s_valid/s_ready    action, reg_select, write_data, request_mask
//   m_       out        m_valid/m_ready    read_data, vector_valid, vector_address,
//                                          halted, master_enabled
//
// One item per cycle sustained while m_ready stays high; an item passes the input register, then the result register.
// The state update for an item is single-pass logic between those two registers.
// Reset (aresetn low, synchronous) clears both valid flags and all controller state.
// A stalled result holds in the result register; the input register still takes an
// item as long as the held one can move on in the same cycle.
module interrupt_priority_controller_core
    import ipc_pkg::*;
#(
    parameter int unsigned SWITCH_DELAY = 2
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [2:0]           s_action,
    input  logic                 s_reg_select,
    input  logic [7:0]           s_write_data,
    input  logic [SRC_COUNT-1:0] s_request_mask,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [7:0]           m_read_data,
    output logic                 m_vector_valid,
    output logic [7:0]           m_vector_address,
    output logic                 m_halted,
    output logic                 m_master_enabled
);

    localparam int unsigned CNT_W = $clog2(SWITCH_DELAY + 1);

    item_t   s_item;
    item_t   item;
    logic    item_valid;
    logic    advance;
    result_t result;
    logic    out_valid_reg;
    result_t out_reg;

    assign s_item.action       = action_t'(s_action);
    assign s_item.reg_select   = s_reg_select;
    assign s_item.write_data   = s_write_data;
    assign s_item.request_mask = s_request_mask;

    // Move the held item on when the result register is free or draining
    assign advance = item_valid && (!out_valid_reg || m_ready);

    ipc_in_reg u_in_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_item     (s_item),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    ipc_state #(
        .SWITCH_DELAY (SWITCH_DELAY),
        .CNT_W        (CNT_W)
    ) u_state (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .item    (item),
        .result  (result)
    );

    // Hold result valid until taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    // Load result payload
    always_ff @(posedge aclk) begin
        if (advance) begin
            out_reg <= result;
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_read_data      = out_reg.read_data;
    assign m_vector_valid   = out_reg.vector_valid;
    assign m_vector_address = out_reg.vector_address;
    assign m_halted         = out_reg.halted;
    assign m_master_enabled = out_reg.master_enabled;

    // Every item that moves on shows up as a result in the next cycle
    a_advance_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> m_valid)
        else $error("item advanced without a result");

    // A dispatch always drops the master enable
    a_dispatch_drops_me: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_vector_valid) |-> !m_master_enabled)
        else $error("master enable still set after dispatch");

    // Dispatched vectors are on the 8-byte grid from 0x40 to 0x60
    a_vector_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_vector_valid) |->
            (m_vector_address[2:0] == 3'b000 && m_vector_address >= 8'h40
             && m_vector_address <= 8'h60))
        else $error("vector address out of range");

    // No dispatch means a zero vector address
    a_vector_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_vector_valid) |-> (m_vector_address == 8'h00))
        else $error("vector address set without dispatch");

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// Testbench for interrupt_priority_controller_core: directed and random events on the s_ channel,
// results predicted by a local controller model and checked on the m_ channel.
// Depends on ipc_pkg and the core RTL.
module testbench;
    import ipc_pkg::*;

    localparam int unsigned IME_DELAY    = 2;
    localparam int unsigned RESET_CYCLES = 12;
    localparam int unsigned STALL_LIMIT  = 2000;
    localparam int unsigned DRAIN_CYCLES = 8;
    localparam int unsigned RANDOM_ITEMS = 500;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_valid;
    logic                 s_ready;
    logic [2:0]           s_action;
    logic                 s_reg_select;
    logic [7:0]           s_write_data;
    logic [SRC_COUNT-1:0] s_request_mask;
    logic                 m_valid;
    logic                 m_ready;
    logic [7:0]           m_read_data;
    logic                 m_vector_valid;
    logic [7:0]           m_vector_address;
    logic                 m_halted;
    logic                 m_master_enabled;

    // Local copy of the controller state
    logic [7:0] pend_flags;
    logic [7:0] irq_mask;
    logic       ime;
    logic [1:0] ime_off_cnt;
    logic [1:0] ime_on_cnt;
    logic       halt_state;

    result_t expected_results[$];
    int      error_count;
    int      idle_cycles;
    bit      no_gaps;

    interrupt_priority_controller_core #(
        .SWITCH_DELAY(IME_DELAY)
    ) dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_action        (s_action),
        .s_reg_select    (s_reg_select),
        .s_write_data    (s_write_data),
        .s_request_mask  (s_request_mask),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_read_data     (m_read_data),
        .m_vector_valid  (m_vector_valid),
        .m_vector_address(m_vector_address),
        .m_halted        (m_halted),
        .m_master_enabled(m_master_enabled)
    );

    always #2 aclk = ~aclk;

    // Apply one event to the local state and return the result it should produce
    function automatic result_t controller_step(item_t it);
        result_t              res;
        logic [SRC_COUNT-1:0] ready_src;
        int                   src;
        res = '0;
        case (it.action)
            ACT_WRITE: begin
                if (it.reg_select == REG_PENDING) pend_flags = it.write_data;
                else irq_mask = it.write_data;
            end
            ACT_READ: begin
                res.read_data = (it.reg_select == REG_PENDING) ? pend_flags : irq_mask;
            end
            ACT_REQUEST: begin
                if ((it.request_mask & irq_mask[SRC_COUNT-1:0]) != '0) halt_state = 1'b0;
                pend_flags = pend_flags | {3'b000, it.request_mask};
            end
            ACT_SERVICE: begin
                // lowest source that is pending and enabled wins
                ready_src = pend_flags[SRC_COUNT-1:0] & irq_mask[SRC_COUNT-1:0];
                if (ime) begin
                    for (src = 0; src < SRC_COUNT; src++) begin
                        if (!res.vector_valid && ready_src[src]) begin
                            pend_flags[src]    = 1'b0;
                            ime                = 1'b0;
                            res.vector_valid   = 1'b1;
                            res.vector_address = VEC_BASE + 8'(src * 8);
                        end
                    end
                end
            end
            ACT_TICK: begin
                // disable countdown first, so enable wins when both land together
                if (ime_off_cnt != 2'd0) begin
                    if (ime_off_cnt == 2'd1) ime = 1'b0;
                    ime_off_cnt = ime_off_cnt - 2'd1;
                end
                if (ime_on_cnt != 2'd0) begin
                    if (ime_on_cnt == 2'd1) ime = 1'b1;
                    ime_on_cnt = ime_on_cnt - 2'd1;
                end
            end
            ACT_ENABLE: begin
                ime_on_cnt  = 2'(IME_DELAY);
                ime_off_cnt = 2'd0;
            end
            ACT_DISABLE: begin
                ime_off_cnt = 2'(IME_DELAY);
                ime_on_cnt  = 2'd0;
            end
            ACT_HALT: begin
                halt_state = 1'b1;
            end
        endcase
        res.halted         = halt_state;
        res.master_enabled = ime;
        return res;
    endfunction

    // Mostly no gap, some short ones, a few long ones
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (no_gaps || roll < 60) return 0;
        if (roll < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Offer one item, hold it until accepted, then record its expected result
    task automatic send_item(action_t act, logic sel, logic [7:0] data,
                             logic [SRC_COUNT-1:0] req);
        item_t it;
        int    gap;
        it.action       = act;
        it.reg_select   = sel;
        it.write_data   = data;
        it.request_mask = req;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_action       <= act;
        s_reg_select   <= sel;
        s_write_data   <= data;
        s_request_mask <= req;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        expected_results.push_back(controller_step(it));
    endtask

    // Hold off the sender until every outstanding result has arrived
    task automatic wait_for_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (expected_results.size() != 0) @(posedge aclk);
    endtask

    task automatic test_register_access();
        send_item(ACT_WRITE, REG_PENDING, 8'hFF, 5'h00);
        send_item(ACT_READ,  REG_PENDING, 8'h00, 5'h1F);
        send_item(ACT_WRITE, REG_ENABLE,  8'hFF, 5'h00);
        send_item(ACT_READ,  REG_ENABLE,  8'hFF, 5'h00);
        send_item(ACT_WRITE, REG_PENDING, 8'h00, 5'h1F);
        send_item(ACT_READ,  REG_PENDING, 8'h00, 5'h00);
        send_item(ACT_WRITE, REG_ENABLE,  8'h00, 5'h00);
    endtask

    // A disabled source leaves halt set; an enabled one clears it
    task automatic test_halt_wake();
        send_item(ACT_HALT,    REG_PENDING, 8'h00, 5'h00);
        send_item(ACT_REQUEST, REG_PENDING, 8'h00, 5'h1F);
        send_item(ACT_WRITE,   REG_ENABLE,  8'h10, 5'h00);
        send_item(ACT_REQUEST, REG_ENABLE,  8'hFF, 5'h10);
    endtask

    task automatic test_dispatch_priority();
        send_item(ACT_WRITE,   REG_ENABLE,  8'h1F, 5'h00);
        send_item(ACT_WRITE,   REG_PENDING, 8'hFF, 5'h00);
        // master enable still clear: nothing goes out
        send_item(ACT_SERVICE, REG_PENDING, 8'h00, 5'h00);
        send_item(ACT_ENABLE,  REG_PENDING, 8'h00, 5'h00);
        send_item(ACT_TICK,    REG_PENDING, 8'h00, 5'h00);
        send_item(ACT_TICK,    REG_PENDING, 8'h00, 5'h00);
        send_item(ACT_SERVICE, REG_PENDING, 8'h00, 5'h00);
        send_item(ACT_READ,    REG_PENDING, 8'h00, 5'h00);
        // only the upper bits pending: service finds nothing, master enable stays
        send_item(ACT_WRITE,   REG_PENDING, 8'hE0, 5'h00);
        send_item(ACT_ENABLE,  REG_PENDING, 8'h00, 5'h00);
        send_item(ACT_TICK,    REG_PENDING, 8'h00, 5'h00);
        send_item(ACT_TICK,    REG_PENDING, 8'h00, 5'h00);
        send_item(ACT_SERVICE, REG_PENDING, 8'h00, 5'h00);
    endtask

    task automatic test_delayed_disable();
        send_item(ACT_DISABLE, REG_PENDING, 8'h00, 5'h00);
        send_item(ACT_TICK,    REG_PENDING, 8'h00, 5'h00);
        send_item(ACT_TICK,    REG_PENDING, 8'h00, 5'h00);
    endtask

    task automatic test_random_traffic();
        int      sent;
        int      roll;
        action_t act;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            no_gaps = (sent >= 200 && sent < 260);
            if ($urandom_range(0, 3) == 0) begin
                // arm sources, open the master enable after its delay and service
                send_item(ACT_WRITE,   REG_ENABLE, 8'($urandom), 5'($urandom));
                send_item(ACT_REQUEST, 1'($urandom), 8'($urandom), 5'($urandom_range(1, 31)));
                send_item(ACT_ENABLE,  1'($urandom), 8'($urandom), 5'($urandom));
                send_item(ACT_TICK,    1'($urandom), 8'($urandom), 5'($urandom));
                send_item(ACT_TICK,    1'($urandom), 8'($urandom), 5'($urandom));
                send_item(ACT_SERVICE, 1'($urandom), 8'($urandom), 5'($urandom));
                sent += 6;
            end else begin
                roll = $urandom_range(0, 99);
                act  = action_t'(roll < 10 ? ACT_WRITE   :
                                 roll < 22 ? ACT_READ    :
                                 roll < 37 ? ACT_REQUEST :
                                 roll < 57 ? ACT_SERVICE :
                                 roll < 77 ? ACT_TICK    :
                                 roll < 87 ? ACT_ENABLE  :
                                 roll < 93 ? ACT_DISABLE : ACT_HALT);
                send_item(act, 1'($urandom), 8'($urandom), 5'($urandom));
                sent++;
            end
        end
        no_gaps = 1'b0;
    endtask

    // Compare one field and count a mismatch
    task automatic check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            error_count++;
        end
    endtask

    // Check each accepted result against the oldest expectation; watch for a hang
    always @(posedge aclk) begin
        result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                $error("result with no item outstanding");
                error_count++;
            end else begin
                want = expected_results.pop_front();
                check_field("read_data",      want.read_data,      m_read_data);
                check_field("vector_valid",   want.vector_valid,   m_vector_valid);
                check_field("vector_address", want.vector_address, m_vector_address);
                check_field("halted",         want.halted,         m_halted);
                check_field("master_enabled", want.master_enabled, m_master_enabled);
            end
        end
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles + 1 >= STALL_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Result side: runs of ready broken by random stalls
    initial begin
        int run;
        int gap;
        m_ready <= 1'b0;
        @(posedge aclk);
        while (aresetn !== 1'b1) @(posedge aclk);
        forever begin
            m_ready <= 1'b1;
            run = $urandom_range(1, 12);
            repeat (run) @(posedge aclk);
            gap = pick_gap();
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
    end

    initial begin
        aclk           = 1'b0;
        idle_cycles    = 0;
        error_count    = 0;
        no_gaps        = 1'b0;
        pend_flags     = 8'h00;
        irq_mask       = 8'h00;
        ime            = 1'b0;
        ime_off_cnt    = 2'd0;
        ime_on_cnt     = 2'd0;
        halt_state     = 1'b0;
        aresetn        <= 1'b0;
        s_valid        <= 1'b0;
        s_action       <= ACT_WRITE;
        s_reg_select   <= REG_PENDING;
        s_write_data   <= 8'h00;
        s_request_mask <= '0;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        test_register_access();
        test_halt_wake();
        wait_for_results();
        test_dispatch_priority();
        test_delayed_disable();
        test_random_traffic();
        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (error_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
